// ----- sv/optical_level_switch_current_classifier_assert.svh -----
// Assertion macros for the classifier checker.
`ifndef OPTICAL_LEVEL_SWITCH_CURRENT_CLASSIFIER_ASSERT_SVH
`define OPTICAL_LEVEL_SWITCH_CURRENT_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define OLSCC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define OLSCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/olscc_pkg.sv -----
// Types and constants of the optical level switch current classifier.
package olscc_pkg;

  localparam int unsigned CUR_W  = 14;
  localparam int unsigned RAW_W  = 16;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned WIN_W  = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic signed [CUR_W-1:0] CUR_MAX = 14'sd8191;
  localparam logic signed [CUR_W-1:0] CUR_MIN = -14'sd8192;

  typedef enum logic [2:0] {
    ST_ON       = 3'd0,
    ST_OFF      = 3'd1,
    ST_TEST     = 3'd2,
    ST_LIGHT    = 3'd3,
    ST_ERROR    = 3'd4,
    ST_HW_ERROR = 3'd5
  } switch_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 3'd0,
    REG_OFFSET = 3'd1,
    REG_ON     = 3'd2,
    REG_OFF    = 3'd3,
    REG_TEST   = 3'd4,
    REG_LIGHT  = 3'd5,
    REG_WINDOW = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_WRITE,
    S_WALK,
    S_FINISH
  } seq_state_t;

endpackage

// ----- sv/optical_level_switch_current_classifier.sv -----
// Top level of the optical level switch current classifier.
//
// Input stream: one transfer per evaluation tick. tdata carries raw_sample,
// tuser carries sample_valid and sensor_enabled. Output stream: one transfer
// per tick with switch_state and failure in tuser, variation and
// scaled_current in tdata. Registers are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce it. An invalid sample goes from the
// multiply step straight to the finish step; a valid one passes the scale,
// history write and min/max walk steps, the walk covering the held history
// entries after the push (up to HISTORY_DEPTH). The walk reads one history
// entry per cycle from the registered read port of the history memory.
// One item is in work at a time; s_axis_tready is high only while idle.
// The output register holds a finished result while the receiver stalls;
// the next item is still accepted and waits in the finish step until the
// output register is free.
// Reset (rst, synchronous) empties the history, clears the failure flag and
// the last variation, and restores the register defaults.
module optical_level_switch_current_classifier #(
  parameter int unsigned HISTORY_DEPTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] raw_sample
  input  logic [1:0]  s_axis_tuser,   // [0] sample_valid, [1] sensor_enabled
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [13:0] variation, [27:14] scaled_current
  output logic [3:0]  m_axis_tuser,   // [2:0] switch_state, [3] failure
  input  logic        cfg_we,
  input  logic [olscc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [olscc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CUR_W = olscc_pkg::CUR_W;

  // Configuration registers
  logic [olscc_pkg::GAIN_W-1:0] gain;
  logic signed [CUR_W-1:0]      offset;
  logic signed [CUR_W-1:0]      on_level;
  logic signed [CUR_W-1:0]      off_level;
  logic signed [CUR_W-1:0]      test_level;
  logic signed [CUR_W-1:0]      light_level;
  logic [olscc_pkg::WIN_W-1:0]  window;

  // Sequencer and datapath
  olscc_pkg::seq_state_t state, state_next;
  logic [olscc_pkg::RAW_W-1:0]  samp_raw;
  logic                         samp_valid;
  logic                         samp_en;
  logic [31:0]                  prod;
  logic signed [CUR_W-1:0]      cur;
  logic [CW-1:0]                cnt;
  logic [AW-1:0]                head;
  logic [CW-1:0]                rd_idx;
  logic                         rd_pend;
  logic signed [CUR_W-1:0]      rd_data;
  logic signed [CUR_W-1:0]      mn;
  logic signed [CUR_W-1:0]      mx;
  olscc_pkg::switch_state_t     res_state;
  logic                         failure_flag;
  logic [CUR_W-1:0]             last_variation;
  logic signed [CUR_W-1:0]      history [HISTORY_DEPTH];

  logic                         accept;
  logic                         rd_issue;
  logic                         out_free;
  logic signed [21:0]           scaled;
  logic signed [CUR_W-1:0]      sat;
  logic                         hit_on, hit_off, hit_test, hit_light;
  logic signed [CUR_W:0]        span;

  // Window test: |cur - level| < window
  function automatic logic in_win(input logic signed [13:0] c,
                                  input logic signed [13:0] lvl,
                                  input logic [12:0] w);
    logic signed [14:0] d;
    logic [14:0]        mag;
    d   = 15'(c) - 15'(lvl);
    mag = d[14] ? 15'(-d) : 15'(d);
    return mag < {2'b00, w};
  endfunction

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign rd_issue = (state == olscc_pkg::S_WALK) && (rd_idx < cnt);

  // Scale and saturate the registered product
  assign scaled = $signed({2'b00, prod[31:12]}) - 22'(offset);
  always_comb begin
    if (scaled > 22'(olscc_pkg::CUR_MAX)) begin
      sat = olscc_pkg::CUR_MAX;
    end else if (scaled < 22'(olscc_pkg::CUR_MIN)) begin
      sat = olscc_pkg::CUR_MIN;
    end else begin
      sat = scaled[CUR_W-1:0];
    end
  end

  assign hit_on    = in_win(cur, on_level, window);
  assign hit_off   = in_win(cur, off_level, window);
  assign hit_test  = in_win(cur, test_level, window);
  assign hit_light = in_win(cur, light_level, window);
  assign span      = (CUR_W+1)'(mx) - (CUR_W+1)'(mn);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain        <= 16'd4096;
      offset      <= '0;
      on_level    <= '0;
      off_level   <= '0;
      test_level  <= '0;
      light_level <= '0;
      window      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        olscc_pkg::REG_GAIN:   gain        <= cfg_data;
        olscc_pkg::REG_OFFSET: offset      <= cfg_data[CUR_W-1:0];
        olscc_pkg::REG_ON:     on_level    <= cfg_data[CUR_W-1:0];
        olscc_pkg::REG_OFF:    off_level   <= cfg_data[CUR_W-1:0];
        olscc_pkg::REG_TEST:   test_level  <= cfg_data[CUR_W-1:0];
        olscc_pkg::REG_LIGHT:  light_level <= cfg_data[CUR_W-1:0];
        olscc_pkg::REG_WINDOW: window      <= cfg_data[olscc_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= olscc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      olscc_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = olscc_pkg::S_MUL;
      end
      olscc_pkg::S_MUL: begin
        state_next = samp_valid ? olscc_pkg::S_SCALE : olscc_pkg::S_FINISH;
      end
      olscc_pkg::S_SCALE: state_next = olscc_pkg::S_WRITE;
      olscc_pkg::S_WRITE: state_next = olscc_pkg::S_WALK;
      olscc_pkg::S_WALK: begin
        if (!rd_issue && !rd_pend) state_next = olscc_pkg::S_FINISH;
      end
      olscc_pkg::S_FINISH: begin
        if (out_free) state_next = olscc_pkg::S_IDLE;
      end
      default: state_next = olscc_pkg::S_IDLE;
    endcase
  end

  // History memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == olscc_pkg::S_WRITE) begin
      history[head] <= cur;
    end
    rd_data <= history[rd_idx[AW-1:0]];
  end

  // Control state: fill count, head, failure flag, last variation
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt            <= '0;
      head           <= '0;
      failure_flag   <= 1'b0;
      last_variation <= '0;
      rd_pend        <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
      case (state)
        olscc_pkg::S_MUL: begin
          if (!samp_valid && !samp_en) failure_flag <= 1'b0;
        end
        olscc_pkg::S_WRITE: begin
          head <= (head == AW'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1;
          if (cnt != CW'(HISTORY_DEPTH)) cnt <= cnt + 1'b1;
          failure_flag <= !(hit_on || hit_off || hit_test || hit_light);
        end
        olscc_pkg::S_WALK: begin
          if (!rd_issue && !rd_pend) last_variation <= span[CUR_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_raw   <= s_axis_tdata;
      samp_valid <= s_axis_tuser[0];
      samp_en    <= s_axis_tuser[1];
    end
    case (state)
      olscc_pkg::S_MUL: begin
        prod      <= 32'(gain) * 32'(samp_raw);
        cur       <= '0;
        res_state <= samp_en ? olscc_pkg::ST_HW_ERROR : olscc_pkg::ST_OFF;
      end
      olscc_pkg::S_SCALE: cur <= sat;
      olscc_pkg::S_WRITE: begin
        rd_idx <= '0;
        mn     <= cur;
        mx     <= cur;
        if (hit_on)         res_state <= olscc_pkg::ST_ON;
        else if (hit_off)   res_state <= olscc_pkg::ST_OFF;
        else if (hit_test)  res_state <= olscc_pkg::ST_TEST;
        else if (hit_light) res_state <= olscc_pkg::ST_LIGHT;
        else                res_state <= olscc_pkg::ST_ERROR;
      end
      olscc_pkg::S_WALK: begin
        if (rd_issue) rd_idx <= rd_idx + 1'b1;
        if (rd_pend) begin
          if (rd_data < mn) mn <= rd_data;
          if (rd_data > mx) mx <= rd_data;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == olscc_pkg::S_FINISH && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == olscc_pkg::S_FINISH && out_free) begin
      m_axis_tdata <= {4'b0000, cur, last_variation};
      m_axis_tuser <= {failure_flag, res_state};
    end
  end

endmodule

// ----- sv/olscc_checker.sv -----
// Port-level checker for the classifier, bound to the top level.
`include "optical_level_switch_current_classifier_assert.svh"

module olscc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  logic [35:0] out_word;
  logic [2:0]  st;
  logic        fail;
  logic        match;

  assign st    = m_axis_tuser[2:0];
  assign fail  = m_axis_tuser[3];
  assign match = (st == olscc_pkg::ST_ON) || (st == olscc_pkg::ST_OFF) ||
                 (st == olscc_pkg::ST_TEST) || (st == olscc_pkg::ST_LIGHT);
  assign out_word = {m_axis_tuser, m_axis_tdata};

  // Hold a stalled result
  `OLSCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(out_word), "stalled result changed")
  // One item in work at a time
  `OLSCC_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after transfer")
  // Error result always raises failure
  `OLSCC_ASSERT_IMPL(a_err_fail, m_axis_tvalid && st == olscc_pkg::ST_ERROR, fail, "error without failure")
  // Matched window or disabled channel clears failure
  `OLSCC_ASSERT_IMPL(a_match_clear, m_axis_tvalid && match, !fail, "failure with matched state")
  // Hardware error carries no current
  `OLSCC_ASSERT_IMPL(a_hw_zero, m_axis_tvalid && st == olscc_pkg::ST_HW_ERROR, m_axis_tdata[27:14] == 14'd0, "hw error with current")

endmodule

bind optical_level_switch_current_classifier olscc_checker u_olscc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- bench/optical_level_switch_current_classifier_tb.sv -----
// Self-checking testbench for the optical level switch current classifier.
`timescale 1ns / 1ps

module optical_level_switch_current_classifier_tb;

  localparam int HIST_DEPTH = 20;
  localparam int PHASES = 9;
  localparam int TICKS_PER_PHASE = 48;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_TAIL = 30;
  // Index outside the register map; a write there must change nothing
  localparam logic [olscc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic [2:0]         state;
    bit                 failure;
    logic [13:0]        variation;
    logic signed [13:0] scaled;
  } tick_result_t;

  typedef struct {
    bit           is_write;
    logic [2:0]   reg_idx;
    logic [15:0]  reg_val;
    logic [15:0]  raw;
    bit           valid;
    bit           en;
    bit           known;
    tick_result_t want;
  } stim_row_t;

  typedef enum {RDY_FREE, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] raw_sample
  logic [1:0]  s_axis_tuser = '0;   // [0] sample_valid, [1] sensor_enabled
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [13:0] variation, [27:14] scaled_current
  logic [3:0]  m_axis_tuser;        // [2:0] switch_state, [3] failure
  logic        cfg_we = 1'b0;
  logic [olscc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [olscc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the block's registers and state
  logic [15:0]        gain_r = 16'd4096;
  logic signed [13:0] offset_r = '0;
  logic signed [13:0] on_r = '0;
  logic signed [13:0] off_r = '0;
  logic signed [13:0] test_r = '0;
  logic signed [13:0] light_r = '0;
  logic [12:0]        window_r = '0;
  logic signed [13:0] hist_buf [HIST_DEPTH];
  int                 hist_held = 0;
  int                 hist_head = 0;
  bit                 fail_flag = 1'b0;
  logic [13:0]        last_var = '0;

  tick_result_t expected_ticks[$];
  stim_row_t    directed[$];
  int           mismatch_count = 0;

  // Sender pacing
  int unsigned burst_left = 0;
  bit          offering = 1'b0;

  // Receiver stall pattern
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  ready_mode_t ready_mode = RDY_FREE;

  optical_level_switch_current_classifier #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("optical_level_switch_current_classifier_tb: done, errors");
    $finish;
  end

  // Strict window test around one level
  function automatic bit near(input int cur, input int lvl);
    int d;
    d = cur - lvl;
    if (d < 0) d = -d;
    return d < int'(window_r);
  endfunction

  // Update the register mirror; unknown indexes change nothing
  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      olscc_pkg::REG_GAIN:   gain_r = val;
      olscc_pkg::REG_OFFSET: offset_r = val[13:0];
      olscc_pkg::REG_ON:     on_r = val[13:0];
      olscc_pkg::REG_OFF:    off_r = val[13:0];
      olscc_pkg::REG_TEST:   test_r = val[13:0];
      olscc_pkg::REG_LIGHT:  light_r = val[13:0];
      olscc_pkg::REG_WINDOW: window_r = val[12:0];
      default: ;
    endcase
  endfunction

  // Scale, record and classify one evaluation tick
  function automatic tick_result_t classify_tick(input logic [15:0] raw, input bit valid,
                                                 input bit en);
    tick_result_t r;
    logic [31:0]  prod;
    longint       s;
    int           cur;
    int           lo;
    int           hi;
    cur = 0;
    if (valid) begin
      prod = 32'(gain_r) * 32'(raw);
      s = longint'(prod >> 12) - longint'(offset_r);
      if (s > olscc_pkg::CUR_MAX) s = olscc_pkg::CUR_MAX;
      if (s < olscc_pkg::CUR_MIN) s = olscc_pkg::CUR_MIN;
      cur = int'(s);
      hist_buf[hist_head] = 14'(cur);
      hist_head = (hist_head + 1 == HIST_DEPTH) ? 0 : hist_head + 1;
      if (hist_held < HIST_DEPTH) hist_held++;
      lo = cur;
      hi = cur;
      for (int i = 0; i < hist_held; i++) begin
        if (hist_buf[i] < lo) lo = hist_buf[i];
        if (hist_buf[i] > hi) hi = hist_buf[i];
      end
      last_var = 14'(hi - lo);
      fail_flag = 1'b0;
      if (near(cur, on_r)) r.state = olscc_pkg::ST_ON;
      else if (near(cur, off_r)) r.state = olscc_pkg::ST_OFF;
      else if (near(cur, test_r)) r.state = olscc_pkg::ST_TEST;
      else if (near(cur, light_r)) r.state = olscc_pkg::ST_LIGHT;
      else begin
        r.state = olscc_pkg::ST_ERROR;
        fail_flag = 1'b1;
      end
    end else if (en) begin
      r.state = olscc_pkg::ST_HW_ERROR;
    end else begin
      r.state = olscc_pkg::ST_OFF;
      fail_flag = 1'b0;
    end
    r.failure = fail_flag;
    r.variation = last_var;
    r.scaled = 14'(cur);
    return r;
  endfunction

  // Table builders for the directed part
  function automatic void add_write(input logic [2:0] idx, input logic [15:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    directed.insert(directed.size(), row);
  endfunction

  function automatic void add_tick(input logic [15:0] raw, input bit valid, input bit en);
    stim_row_t row;
    row = '{default: '0};
    row.raw = raw;
    row.valid = valid;
    row.en = en;
    directed.insert(directed.size(), row);
  endfunction

  function automatic void add_known(input logic [15:0] raw, input bit valid, input bit en,
                                    input logic [2:0] st, input bit f, input int vari,
                                    input int cur);
    stim_row_t row;
    row = '{default: '0};
    row.raw = raw;
    row.valid = valid;
    row.en = en;
    row.known = 1'b1;
    row.want.state = st;
    row.want.failure = f;
    row.want.variation = 14'(vari);
    row.want.scaled = 14'(cur);
    directed.insert(directed.size(), row);
  endfunction

  // Offer one tick, wait for the transfer, then pace the next one
  task automatic send_tick(input logic [15:0] raw, input bit valid, input bit en,
                           input bit known, input tick_result_t want);
    tick_result_t got;
    int unsigned  pause;
    s_axis_tdata <= raw;
    s_axis_tuser <= {en, valid};
    s_axis_tvalid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    got = classify_tick(raw, valid, en);
    expected_ticks.insert(expected_ticks.size(), known ? want : got);
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (pause != 0) begin
        s_axis_tvalid <= 1'b0;
        offering = 1'b0;
        repeat (pause) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Drop valid if a burst is still open
  task automatic close_burst();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold until every predicted tick has come out
  task automatic drain();
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // 14-bit signed register value, extremes favored, upper data bits random
  function automatic logic [15:0] pick_level();
    logic [13:0] v;
    case ($urandom_range(0, 4))
      0: v = 14'h2000;
      1: v = 14'h1FFF;
      2: v = 14'h0000;
      default: v = 14'($urandom_range(0, 16383));
    endcase
    return {2'($urandom_range(0, 3)), v};
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd4096;
      3: return 16'($urandom_range(2048, 8192));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_window();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h1FFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 400));
    endcase
  endfunction

  // Receiver: changing stall pattern, plus one long hold on request
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(8, 80);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (ready_mode)
        RDY_FREE:   m_axis_tready <= 1'b1;
        RDY_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 0);
        RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default:    m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  task automatic check_field(input string label, input integer want, input integer got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every output transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_ticks.size() == 0) begin
        $display("%0t: result with none expected, tuser %0h tdata %0h", $time,
                 m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_ticks.pop_front();
        check_field("switch_state", want.state, m_axis_tuser[2:0]);
        check_field("failure", want.failure, m_axis_tuser[3]);
        check_field("variation", want.variation, m_axis_tdata[13:0]);
        check_field("scaled_current", want.scaled, $signed(m_axis_tdata[27:14]));
      end
    end
  end

  initial begin : stimulus
    tick_result_t none;
    stim_row_t    row;
    logic [15:0]  raw;
    bit           valid;
    bit           en;
    int unsigned  kind;
    int           lvl;
    int           span;
    longint       tgt;
    longint       rw;

    none = '{default: '0};

    // Defaults after reset: unity gain, zero offset and window
    add_known(16'h0000, 1'b0, 1'b1, olscc_pkg::ST_HW_ERROR, 1'b0, 0, 0);
    add_known(16'hFFFF, 1'b0, 1'b0, olscc_pkg::ST_OFF, 1'b0, 0, 0);
    add_known(16'h0000, 1'b1, 1'b0, olscc_pkg::ST_ERROR, 1'b1, 0, 0);
    // Hardware error keeps the failure flag, disabled clears it
    add_known(16'h0000, 1'b0, 1'b1, olscc_pkg::ST_HW_ERROR, 1'b1, 0, 0);
    add_known(16'h0000, 1'b0, 1'b0, olscc_pkg::ST_OFF, 1'b0, 0, 0);
    add_known(16'd8191, 1'b1, 1'b1, olscc_pkg::ST_ERROR, 1'b1, 8191, 8191);
    // Saturate at the top of the range
    add_known(16'hFFFF, 1'b1, 1'b1, olscc_pkg::ST_ERROR, 1'b1, 8191, 8191);
    add_write(olscc_pkg::REG_OFFSET, 16'h1FFF);
    add_known(16'h0000, 1'b1, 1'b1, olscc_pkg::ST_ERROR, 1'b1, 16382, -8191);
    // Invalid tick repeats the last variation with zero current
    add_known(16'h0000, 1'b0, 1'b1, olscc_pkg::ST_HW_ERROR, 1'b1, 16382, 0);
    add_write(olscc_pkg::REG_OFFSET, 16'hE000);
    add_tick(16'd1234, 1'b1, 1'b1);
    add_write(olscc_pkg::REG_GAIN, 16'hFFFF);
    add_write(olscc_pkg::REG_OFFSET, 16'h0000);
    add_tick(16'hFFFF, 1'b1, 1'b0);
    add_tick(16'h0001, 1'b1, 1'b1);
    add_write(olscc_pkg::REG_GAIN, 16'h0000);
    add_tick(16'd5000, 1'b1, 1'b1);
    add_write(olscc_pkg::REG_GAIN, 16'd4096);
    add_write(olscc_pkg::REG_ON, 16'd100);
    add_write(olscc_pkg::REG_OFF, 16'd300);
    add_write(olscc_pkg::REG_TEST, 16'd500);
    add_write(olscc_pkg::REG_LIGHT, 16'h1FFF);
    add_write(olscc_pkg::REG_WINDOW, 16'd10);
    // Each window, its strict edges, and the priority order
    add_tick(16'd100, 1'b1, 1'b1);
    add_tick(16'd109, 1'b1, 1'b1);
    add_tick(16'd110, 1'b1, 1'b1);
    add_tick(16'd91, 1'b1, 1'b1);
    add_tick(16'd90, 1'b1, 1'b1);
    add_tick(16'd300, 1'b1, 1'b1);
    add_tick(16'd500, 1'b1, 1'b1);
    add_tick(16'd8191, 1'b1, 1'b1);
    add_tick(16'hFFFF, 1'b1, 1'b1);
    add_write(REG_SPARE, 16'h0000);
    add_tick(16'd100, 1'b1, 1'b1);
    add_write(olscc_pkg::REG_WINDOW, 16'hFFFF);
    add_tick(16'd8000, 1'b1, 1'b1);
    add_tick(16'h0000, 1'b0, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = $urandom_range(1, 24);

    // Walk the directed table
    foreach (directed[i]) begin
      row = directed[i];
      if (row.is_write) begin
        close_burst();
        drain();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_tick(row.raw, row.valid, row.en, row.known, row.want);
      end
    end

    // Random phases, each with its own register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      close_burst();
      drain();
      if (phase == 0) begin
        write_reg(olscc_pkg::REG_GAIN, 16'h0000);
        write_reg(olscc_pkg::REG_OFFSET, 16'h2000);
        write_reg(olscc_pkg::REG_ON, 16'h2000);
        write_reg(olscc_pkg::REG_OFF, 16'h2000);
        write_reg(olscc_pkg::REG_TEST, 16'h2000);
        write_reg(olscc_pkg::REG_LIGHT, 16'h2000);
        write_reg(olscc_pkg::REG_WINDOW, 16'h0000);
      end else if (phase == PHASES - 1) begin
        write_reg(olscc_pkg::REG_GAIN, 16'hFFFF);
        write_reg(olscc_pkg::REG_OFFSET, 16'h1FFF);
        write_reg(olscc_pkg::REG_ON, 16'h1FFF);
        write_reg(olscc_pkg::REG_OFF, 16'h1FFF);
        write_reg(olscc_pkg::REG_TEST, 16'h1FFF);
        write_reg(olscc_pkg::REG_LIGHT, 16'h1FFF);
        write_reg(olscc_pkg::REG_WINDOW, 16'h1FFF);
      end else begin
        write_reg(olscc_pkg::REG_GAIN, pick_gain());
        write_reg(olscc_pkg::REG_OFFSET, pick_level());
        write_reg(olscc_pkg::REG_ON, pick_level());
        write_reg(olscc_pkg::REG_OFF, pick_level());
        write_reg(olscc_pkg::REG_TEST, pick_level());
        write_reg(olscc_pkg::REG_LIGHT, pick_level());
        write_reg(olscc_pkg::REG_WINDOW, pick_window());
      end
      // Stall the output for a long stretch while ticks keep coming
      if (phase == 2) hold_requests++;

      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 99);
        en = 1'($urandom_range(0, 1));
        valid = 1'b1;
        if (kind < 20) begin
          valid = 1'b0;
          raw = 16'($urandom_range(0, 65535));
        end else if (kind < 30) begin
          raw = 16'($urandom_range(0, 65535));
        end else if (kind < 35) begin
          raw = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        end else begin
          // Aim at one level, landing just inside or outside its window
          case ($urandom_range(0, 3))
            0: lvl = on_r;
            1: lvl = off_r;
            2: lvl = test_r;
            default: lvl = light_r;
          endcase
          span = ((window_r > 500) ? 500 : int'(window_r)) + 3;
          tgt = longint'(lvl) + longint'(offset_r) + longint'($urandom_range(0, 2 * span))
                - longint'(span);
          if (gain_r != 0 && tgt >= 0) begin
            rw = (tgt * 4096) / longint'(gain_r);
            if (rw > 65535) rw = 65535;
            raw = 16'(rw);
          end else begin
            raw = 16'($urandom_range(0, 65535));
          end
        end
        send_tick(raw, valid, en, 1'b0, none);
      end
    end

    close_burst();
    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && expected_ticks.size() == 0) begin
      $display("optical_level_switch_current_classifier_tb: done, clean");
    end else begin
      $display("optical_level_switch_current_classifier_tb: done, errors");
    end
    $finish;
  end

endmodule
